// ===== rtl/iqtmp_pkg.sv =====
// Package for the IQ trimmed-mean power unit.
// Holds the request and result payload types and the fixed field widths.
// Depends on nothing; every other file of the block imports it.
package iqtmp_pkg;

	// Fixed widths of the payload fields.
	localparam int SAMPLE_W = 8;
	localparam int CHAN_W   = 6;
	localparam int SEQ_W    = 32;
	localparam int POWER_W  = 16;

	// One IQ sample request as it enters the block.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_i;
		logic signed [SAMPLE_W-1:0] sample_q;
		logic                       report_ok;
		logic [CHAN_W-1:0]          channel_index;
		logic                       last_sample;
	} sample_item_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [CHAN_W-1:0]  result_channel;
		logic [SEQ_W-1:0]   sequence_number;
		logic [POWER_W-1:0] average_power;
	} result_item_t;

	// A sample reduced to its power, with the report flags it travels with.
	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic               report_ok;
		logic [CHAN_W-1:0]  channel_index;
		logic               last_sample;
	} power_item_t;

endpackage

// ===== rtl/iq_trimmed_mean_power_unit.sv =====
// IQ trimmed-mean power unit: one IQ sample request per cycle in unless held
// off, one result per qualifying report out. The power of the first REF_SAMPLES
// samples of a report is summed while the smallest and largest are tracked; on
// the last sample of a report that is complete and flagged good throughout, the
// unit delivers the channel index, a wrapping 32-bit sequence number and
// (sum - min - max) / (REF_SAMPLES - 2). A sample request can be taken in every
// cycle unless the port is held off; the report state is formed combinationally
// and registered with each accepted sample. A result passes an input register,
// a squaring stage, the accumulator, a trim stage and a reciprocal multiply
// into the result register. Each stage moves on independently, so samples
// keep flowing while a result waits to be taken; the sample port is held off
// only once the trim stage and the accumulator output each hold a further
// result and the two front registers are full.
// Depends on iqtmp_pkg, iqtmp_power, iqtmp_accum and iqtmp_divide.
module iq_trimmed_mean_power_unit #(
	parameter int REF_SAMPLES = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  iqtmp_pkg::sample_item_t sample,
	output logic                    result_valid,
	input  logic                    result_ready,
	output iqtmp_pkg::result_item_t result
);
	import iqtmp_pkg::*;

	localparam int MID_W = $clog2((REF_SAMPLES - 2) * 32768 + 1);

	logic               power_valid;
	logic               power_ready;
	power_item_t        power_item;
	logic               mid_valid;
	logic               mid_ready;
	logic [MID_W-1:0]   mid_sum;
	logic [CHAN_W-1:0]  mid_channel;
	logic [SEQ_W-1:0]   mid_sequence;

	// Input register and squaring.
	iqtmp_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (sample_ready),
		.in_item   (sample),
		.out_valid (power_valid),
		.out_ready (power_ready),
		.out_item  (power_item)
	);

	// Report accumulation and trimming.
	iqtmp_accum #(
		.REF_SAMPLES (REF_SAMPLES)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (power_valid),
		.in_ready  (power_ready),
		.in_item   (power_item),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.mid_sum   (mid_sum),
		.channel   (mid_channel),
		.seq_num   (mid_sequence)
	);

	// Division and result register.
	iqtmp_divide #(
		.REF_SAMPLES (REF_SAMPLES)
	) u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.mid_sum   (mid_sum),
		.channel   (mid_channel),
		.seq_num   (mid_sequence),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_item  (result)
	);

`ifndef SYNTH
	// Sample requests can only be held off by a result that is waiting to be taken.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("sample port stalled without a waiting result");

	// The trimmed mean of 16-bit powers never exceeds the largest single power.
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.average_power <= 16'd32768)
		else $error("average power out of range");

	// The trim stage hands a value to the divider only when the divider can hold it.
	a_mid_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid && mid_ready |=> result_valid)
		else $error("trimmed sum lost on its way to the result register");
`endif

endmodule

// ===== rtl/iqtmp_power.sv =====
// Input register and power stage of the IQ trimmed-mean power unit.
// Registers each sample request, then forms i*i + q*q into a second register.
// Depends on iqtmp_pkg.
module iqtmp_power (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  iqtmp_pkg::sample_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output iqtmp_pkg::power_item_t out_item
);
	import iqtmp_pkg::*;

	logic                       valid_s1;
	sample_item_t               item_s1;
	logic                       valid_s2;
	power_item_t                item_s2;
	logic                       load_s1;
	logic                       load_s2;
	logic signed [2*SAMPLE_W-1:0] sq_i;
	logic signed [2*SAMPLE_W-1:0] sq_q;
	logic [POWER_W-1:0]         power;

	// Each stage takes a new request when it is empty or its content moves on.
	assign load_s2  = !valid_s2 || out_ready;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	// Squares of an 8-bit signed value never exceed 2^14, so the sum fits 16 bits.
	assign sq_i  = item_s1.sample_i * item_s1.sample_i;
	assign sq_q  = item_s1.sample_q * item_s1.sample_q;
	assign power = {1'b0, sq_i[2*SAMPLE_W-2:0]} + {1'b0, sq_q[2*SAMPLE_W-2:0]};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Power register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			item_s2.power         <= power;
			item_s2.report_ok     <= item_s1.report_ok;
			item_s2.channel_index <= item_s1.channel_index;
			item_s2.last_sample   <= item_s1.last_sample;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ===== rtl/iqtmp_accum.sv =====
// Per-report accumulator of the IQ trimmed-mean power unit.
// Keeps count, sum, minimum and maximum of the report and forms sum - min - max.
// Depends on iqtmp_pkg.
module iqtmp_accum #(
	parameter int REF_SAMPLES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  iqtmp_pkg::power_item_t         in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [$clog2((REF_SAMPLES-2)*32768+1)-1:0] mid_sum,
	output logic [iqtmp_pkg::CHAN_W-1:0]   channel,
	output logic [iqtmp_pkg::SEQ_W-1:0]    seq_num
);
	import iqtmp_pkg::*;

	localparam int CNT_W = $clog2(REF_SAMPLES + 1);
	localparam int SUM_W = $clog2(REF_SAMPLES * 32768 + 1);
	localparam int MID_W = $clog2((REF_SAMPLES - 2) * 32768 + 1);

	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [POWER_W-1:0] min_q;
	logic [POWER_W-1:0] max_q;
	logic               bad_q;
	logic [SEQ_W-1:0]   result_count_q;

	logic               take;
	logic [CNT_W-1:0]   count_next;
	logic [SUM_W-1:0]   sum_next;
	logic [POWER_W-1:0] min_next;
	logic [POWER_W-1:0] max_next;
	logic               bad_next;
	logic               produce;
	logic               accept;
	logic               load_s3;
	logic               load_s4;

	logic               valid_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic [POWER_W-1:0] min_s3;
	logic [POWER_W-1:0] max_s3;
	logic [CHAN_W-1:0]  chan_s3;
	logic [SEQ_W-1:0]   seq_s3;

	logic               valid_s4;
	logic [MID_W-1:0]   mid_s4;
	logic [CHAN_W-1:0]  chan_s4;
	logic [SEQ_W-1:0]   seq_s4;

	// Pipeline flow: a stage loads when empty or when its content moves on.
	assign load_s4  = !valid_s4 || out_ready;
	assign load_s3  = !valid_s3 || load_s4;
	assign in_ready = load_s3;
	assign accept   = in_valid && load_s3;

	// Report state update; samples past the reference count touch only the bad flag.
	always_comb begin
		take       = count_q < CNT_W'(REF_SAMPLES);
		count_next = count_q;
		sum_next   = sum_q;
		min_next   = min_q;
		max_next   = max_q;
		if (take) begin
			count_next = count_q + CNT_W'(1);
			sum_next   = sum_q + SUM_W'(in_item.power);
			if (in_item.power < min_q) begin
				min_next = in_item.power;
			end
			if (in_item.power > max_q) begin
				max_next = in_item.power;
			end
		end
		bad_next = bad_q || !in_item.report_ok;
		produce  = in_item.last_sample && (count_next == CNT_W'(REF_SAMPLES)) && !bad_next;
	end

	// Report state, cleared at the end of every report; the sequence counter runs on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			sum_q          <= '0;
			min_q          <= '1;
			max_q          <= '0;
			bad_q          <= 1'b0;
			result_count_q <= '0;
		end else if (accept) begin
			if (in_item.last_sample) begin
				count_q <= '0;
				sum_q   <= '0;
				min_q   <= '1;
				max_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				sum_q   <= sum_next;
				min_q   <= min_next;
				max_q   <= max_next;
				bad_q   <= bad_next;
			end
			if (produce) begin
				result_count_q <= result_count_q + SEQ_W'(1);
			end
		end
	end

	// Stage three holds the finished totals of a report that gives a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= accept && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			sum_s3  <= sum_next;
			min_s3  <= min_next;
			max_s3  <= max_next;
			chan_s3 <= in_item.channel_index;
			seq_s3  <= result_count_q;
		end
	end

	// Stage four drops the smallest and largest power from the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (load_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4 && valid_s3) begin
			mid_s4  <= MID_W'(sum_s3 - SUM_W'(min_s3) - SUM_W'(max_s3));
			chan_s4 <= chan_s3;
			seq_s4  <= seq_s3;
		end
	end

	assign out_valid = valid_s4;
	assign mid_sum   = mid_s4;
	assign channel   = chan_s4;
	assign seq_num   = seq_s4;

endmodule

// ===== rtl/iqtmp_divide.sv =====
// Constant divider and result register of the IQ trimmed-mean power unit.
// Divides the trimmed sum by REF_SAMPLES - 2 through a reciprocal multiply.
// Depends on iqtmp_pkg.
module iqtmp_divide #(
	parameter int REF_SAMPLES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [$clog2((REF_SAMPLES-2)*32768+1)-1:0] mid_sum,
	input  logic [iqtmp_pkg::CHAN_W-1:0]   channel,
	input  logic [iqtmp_pkg::SEQ_W-1:0]    seq_num,
	output logic                           out_valid,
	input  logic                           out_ready,
	output iqtmp_pkg::result_item_t        out_item
);
	import iqtmp_pkg::*;

	localparam int MID_W   = $clog2((REF_SAMPLES - 2) * 32768 + 1);
	localparam int DIVISOR = REF_SAMPLES - 2;
	// A shift of MID_W plus clog2 of the divisor makes the quotient exact.
	localparam int SHIFT   = MID_W + $clog2(DIVISOR);
	localparam int RECIP_W = SHIFT + 1;
	localparam longint unsigned RECIP_VAL =
		((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / DIVISOR;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam int PROD_W  = MID_W + RECIP_W;

	logic                valid_q;
	result_item_t        result_q;
	logic                load;
	logic [PROD_W-1:0]   product;

	assign load     = !valid_q || out_ready;
	assign in_ready = load;

	// Quotient by multiplication with the rounded-up reciprocal.
	assign product = PROD_W'(mid_sum) * PROD_W'(RECIP);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			result_q.result_channel  <= channel;
			result_q.sequence_number <= seq_num;
			result_q.average_power   <= product[SHIFT +: POWER_W];
		end
	end

	assign out_valid = valid_q;
	assign out_item  = result_q;

endmodule

// ===== tb/sv/iq_trimmed_mean_power_unit_tb.sv =====
// Self-checking testbench for the IQ trimmed-mean power unit.
// Depends on iqtmp_pkg and iq_trimmed_mean_power_unit; it predicts every report result
// itself and compares each delivered result against the oldest prediction.
module iq_trimmed_mean_power_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iqtmp_pkg::*;

	localparam int NUM_SAMPLES  = 8;
	localparam int TOTAL_ITEMS  = 1400;
	localparam int STREAM_ITEMS = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 500000;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         sample_valid;
	logic         sample_ready;
	sample_item_t sample;
	logic         result_valid;
	logic         result_ready;
	result_item_t result;

	// Shared testbench state.
	bit           idling_on = 1'b1;
	int           errors = 0;
	int           requests_sent = 0;
	int           cycle_count = 0;
	result_item_t awaited_reports[$];

	// Predicted report state, mirroring what the unit must hold.
	int           taken_count;
	logic [18:0]  power_sum;
	logic [15:0]  power_min;
	logic [15:0]  power_max;
	bit           report_bad;
	logic [31:0]  report_seq;

	iq_trimmed_mean_power_unit #(
		.REF_SAMPLES(NUM_SAMPLES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Idle length: mostly none, often a few cycles, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sample_item_t make_sample(int i, int q, bit ok, int chan, bit last);
		sample_item_t s;
		s.sample_i      = i[7:0];
		s.sample_q      = q[7:0];
		s.report_ok     = ok;
		s.channel_index = chan[5:0];
		s.last_sample   = last;
		return s;
	endfunction

	// A random I or Q component, biased towards the extremes and zero.
	function automatic int pick_component();
		case ($urandom_range(0, 9))
			0: return -128;
			1: return 127;
			2: return 0;
			3: return -1;
			default: return $urandom_range(0, 255) - 128;
		endcase
	endfunction

	function automatic void clear_report_power();
		taken_count = 0;
		power_sum   = '0;
		power_min   = 16'hFFFF;
		power_max   = '0;
		report_bad  = 1'b0;
	endfunction

	// Folds one accepted sample into the predicted report and, on the last sample
	// of a complete good report, queues the trimmed mean it must deliver.
	function automatic void track_report_power(sample_item_t s);
		int           si;
		int           sq;
		logic [15:0]  power;
		logic [18:0]  trimmed;
		result_item_t r;
		si = $signed(s.sample_i);
		sq = $signed(s.sample_q);
		power = 16'(si * si + sq * sq);
		if (!s.report_ok)
			report_bad = 1'b1;
		if (taken_count < NUM_SAMPLES) begin
			power_sum = power_sum + 19'(power);
			if (power < power_min)
				power_min = power;
			if (power > power_max)
				power_max = power;
			taken_count++;
		end
		if (s.last_sample) begin
			if (taken_count >= NUM_SAMPLES && !report_bad) begin
				trimmed = power_sum - 19'(power_min) - 19'(power_max);
				trimmed = trimmed / 19'(NUM_SAMPLES - 2);
				r.result_channel  = s.channel_index;
				r.sequence_number = report_seq;
				r.average_power   = trimmed[15:0];
				awaited_reports.push_back(r);
				report_seq = report_seq + 32'd1;
			end
			clear_report_power();
		end
	endfunction

	// Sends one sample request; called at a falling edge and returns at one.
	task automatic send_sample(sample_item_t s);
		int gap;
		gap = idling_on ? pick_gap() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		track_report_power(s);
		requests_sent++;
		@(negedge clk);
	endtask

	// Sends one report of len random samples; if ragged, the last flags fall at random.
	task automatic send_random_report(int len, int bad_at, bit ragged);
		int  chan;
		bit  last;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 4) == 0)
				chan = $urandom_range(40, 63);
			else
				chan = $urandom_range(0, 39);
			last = ragged ? ($urandom_range(0, 3) == 0) : (k == len - 1);
			send_sample(make_sample(pick_component(), pick_component(), k != bad_at,
				chan, last));
		end
	endtask

	// Full reports at the power extremes, one with samples past the eighth.
	task automatic test_extremes();
		int ext_i[9] = '{-128, 127, 0, 127, -1, 0, 5, -128, -128};
		int ext_q[9] = '{127, -128, 0, 127, 1, -128, -7, 0, -128};
		for (int k = 0; k < NUM_SAMPLES; k++)
			send_sample(make_sample(-128, -128, 1'b1, 63, k == NUM_SAMPLES - 1));
		for (int k = 0; k < 9; k++)
			send_sample(make_sample(ext_i[k], ext_q[k], 1'b1, (k == 8) ? 39 : 0, k == 8));
	endtask

	// A report that ends before enough samples have arrived gives nothing.
	task automatic test_short_report();
		send_sample(make_sample(100, -100, 1'b1, 12, 1'b0));
		send_sample(make_sample(-128, 127, 1'b1, 21, 1'b1));
	endtask

	// A full report flagged bad on one sample gives nothing and costs no sequence number.
	task automatic test_bad_report();
		for (int k = 0; k < NUM_SAMPLES; k++)
			send_sample(make_sample(pick_component(), pick_component(), k != 0, 5,
				k == NUM_SAMPLES - 1));
		for (int k = 0; k < NUM_SAMPLES; k++)
			send_sample(make_sample(pick_component(), pick_component(), 1'b1, 7,
				k == NUM_SAMPLES - 1));
	endtask

	// Mostly well-formed reports, with long, short, bad and ragged ones mixed in.
	task automatic test_random_reports(int target);
		int r;
		int len;
		int bad_at;
		while (requests_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = NUM_SAMPLES;
			else if (r < 82)
				len = $urandom_range(NUM_SAMPLES + 1, NUM_SAMPLES + 4);
			else
				len = $urandom_range(1, NUM_SAMPLES - 1);
			bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
			send_random_report(len, bad_at, r >= 96);
		end
	endtask

	// Back-to-back requests and a receiver that never stalls.
	task automatic test_back_to_back();
		idling_on = 1'b0;
		test_random_reports(requests_sent + STREAM_ITEMS);
		idling_on = 1'b1;
	endtask

	// Result side back-pressure, driven at the falling edge.
	initial begin
		int hold;
		hold = 0;
		result_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!idling_on) begin
				result_ready <= 1'b1;
			end else if (hold > 0) begin
				result_ready <= 1'b0;
				hold--;
			end else begin
				hold = pick_gap();
				result_ready <= (hold == 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	// Compare every delivered result with the oldest prediction.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result, channel %0d sequence %0d power %0d",
					$realtime, result.result_channel, result.sequence_number,
					result.average_power);
				errors++;
			end else begin
				want = awaited_reports.pop_front();
				if (result.result_channel !== want.result_channel) begin
					$display("%0t: result_channel expected %0d actual %0d", $realtime,
						want.result_channel, result.result_channel);
					errors++;
				end
				if (result.sequence_number !== want.sequence_number) begin
					$display("%0t: sequence_number expected %0d actual %0d", $realtime,
						want.sequence_number, result.sequence_number);
					errors++;
				end
				if (result.average_power !== want.average_power) begin
					$display("%0t: average_power expected %0d actual %0d", $realtime,
						want.average_power, result.average_power);
					errors++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("iq_trimmed_mean_power_unit_tb NOT OK");
		$finish;
	end

	// Reset, the test sequence, then drain and report.
	initial begin
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample       <= '0;
		clear_report_power();
		report_seq = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_short_report();
		test_bad_report();
		test_back_to_back();
		test_random_reports(TOTAL_ITEMS);
		sample_valid <= 1'b0;

		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("iq_trimmed_mean_power_unit_tb OK");
		else
			$display("iq_trimmed_mean_power_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/iqtmp_pkg.sv
rtl/iqtmp_power.sv
rtl/iqtmp_accum.sv
rtl/iqtmp_divide.sv
rtl/iq_trimmed_mean_power_unit.sv
tb/sv/iq_trimmed_mean_power_unit_tb.sv
